>>> hw/rtl/lef_pkg.sv
package lef_pkg;

  // Configuration register indexes
  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

  // Field and register widths
  localparam int CFG_DATA_W   = 13;
  localparam int WIDTH_REG_W  = 11;
  localparam int HEIGHT_W     = 13;
  localparam int HEIGHT_LIMIT = 4096;
  localparam int PIX_W        = 8;

  // Item kinds
  localparam logic KIND_FLUSH = 1'b1;

  typedef logic [PIX_W-1:0] pixel_t;

  // Classification of one request, decided at the front
  typedef struct packed {
    logic emit;      // a result is produced
    logic last;      // the result closes the frame
    logic top_ok;    // row above the center lies in the frame
    logic bot_ok;    // row below the center lies in the frame
    logic left_ok;   // column left of the center lies in the frame
    logic right_ok;  // column right of the center lies in the frame
  } lef_flags_t;

endpackage

>>> hw/rtl/lef_ram.sv
module lef_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read, old data on a same-address collision
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> hw/rtl/lef_fifo.sv
module lef_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign rdata = slots[rd_ptr];

  // Store pushed requests
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("push into a full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("pop from an empty queue");

endmodule

>>> hw/rtl/lef_front.sv
module lef_front #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // pixel requests
  input  logic                                  accept,
  input  logic                                  kind,
  input  logic [lef_pkg::PIX_W-1:0]             red_value,
  // configuration
  input  logic                                  cfg_write,
  input  logic [lef_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  logic [lef_pkg::CFG_DATA_W-1:0]        cfg_data,
  output logic                                  restart,
  // classified request
  output logic [$clog2(MAX_WIDTH)-1:0]          addr,
  output lef_pkg::pixel_t                       value,
  output lef_pkg::lef_flags_t                   flags
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int CW = (WW > lef_pkg::WIDTH_REG_W) ? WW : lef_pkg::WIDTH_REG_W;
  localparam int HW = lef_pkg::HEIGHT_W;

  logic [AW-1:0] col;
  logic [HW-1:0] row;
  logic [WW-1:0] width;
  logic [HW-1:0] height;

  logic          c_zero;
  logic [HW:0]   center_row;
  logic          col_wrap;
  logic [CW-1:0] wval;
  logic [HW-1:0] hval;
  logic [WW-1:0] width_next;
  logic [HW-1:0] height_next;

  // Classify the incoming pixel against the frame geometry
  always_comb begin
    c_zero     = (col == '0);
    center_row = {1'b0, row} - (c_zero ? (HW+1)'(2) : (HW+1)'(1));
    col_wrap   = (WW'(col) + WW'(1)) >= width;

    flags.emit     = !center_row[HW] && (center_row[HW-1:0] < height);
    flags.top_ok   = !center_row[HW] && (center_row != '0);
    flags.bot_ok   = ({1'b0, center_row[HW-1:0]} + (HW+1)'(1)) < {1'b0, height};
    flags.left_ok  = c_zero ? (width >= WW'(2)) : (col >= AW'(2));
    flags.right_ok = !c_zero;
    flags.last     = c_zero && (center_row[HW-1:0] == height - HW'(1));

    value = (kind == lef_pkg::KIND_FLUSH) ? '0 : red_value;
    addr  = col;
  end

  // Clamp written geometry into the supported range
  always_comb begin
    wval = CW'(cfg_data[lef_pkg::WIDTH_REG_W-1:0]);
    if (wval == '0) begin
      width_next = WW'(1);
    end else if (wval > CW'(MAX_WIDTH)) begin
      width_next = WW'(MAX_WIDTH);
    end else begin
      width_next = wval[WW-1:0];
    end

    hval = cfg_data[HW-1:0];
    if (hval == '0) begin
      height_next = HW'(1);
    end else if (hval > HW'(lef_pkg::HEIGHT_LIMIT)) begin
      height_next = HW'(lef_pkg::HEIGHT_LIMIT);
    end else begin
      height_next = hval;
    end
  end

  // Decode register writes
  always_comb begin
    unique case (cfg_index)
      lef_pkg::REG_IMAGE_WIDTH:  restart = cfg_write;
      lef_pkg::REG_IMAGE_HEIGHT: restart = cfg_write;
      default:                   restart = 1'b0;
    endcase
  end

  // Geometry registers
  always_ff @(posedge clk) begin
    if (rst) begin
      width  <= WW'(640);
      height <= HW'(480);
    end else if (cfg_write) begin
      if (cfg_index == lef_pkg::REG_IMAGE_WIDTH) begin
        width <= width_next;
      end
      if (cfg_index == lef_pkg::REG_IMAGE_HEIGHT) begin
        height <= height_next;
      end
    end
  end

  // Raster position of the next pixel
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      if (flags.emit && flags.last) begin
        col <= '0;
        row <= '0;
      end else if (col_wrap) begin
        col <= '0;
        row <= row + 1'b1;
      end else begin
        col <= col + 1'b1;
      end
    end
  end

  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    accept && flags.emit && flags.last |=> (col == '0) && (row == '0))
    else $error("position not restarted after frame end");

endmodule

>>> hw/rtl/lef_back.sv
module lef_back #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         restart,
  // requests from the queue
  input  logic                         req_valid,
  output logic                         req_pop,
  input  logic [$clog2(MAX_WIDTH)-1:0] req_addr,
  input  lef_pkg::pixel_t              req_value,
  input  lef_pkg::lef_flags_t          req_flags,
  // results
  output logic                         res_push,
  input  logic                         res_full,
  output lef_pkg::pixel_t              res_edge,
  output logic                         res_last
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int LW = 2 * lef_pkg::PIX_W;

  logic                a_valid;
  logic [AW-1:0]       a_addr;
  lef_pkg::pixel_t     a_value;
  lef_pkg::lef_flags_t a_flags;
  logic                a_leave;

  logic                byp;
  logic [LW-1:0]       byp_data;
  logic [LW-1:0]       ram_q;
  logic [LW-1:0]       line;
  logic [LW-1:0]       wr_data;

  lef_pkg::pixel_t     win1 [3];
  lef_pkg::pixel_t     win2 [3];
  lef_pkg::pixel_t     col_px [3];
  lef_pkg::pixel_t     tap [3][3];
  logic [2:0]          row_ok;
  logic [2:0]          col_ok;
  logic [10:0]         nsum;
  logic [10:0]         center8;
  logic [11:0]         diff;

  // Stage A holds one request while its line data is read
  assign a_leave = a_valid && (!a_flags.emit || !res_full);
  assign req_pop = req_valid && (!a_valid || a_leave);

  // Line buffers: upper row in the high byte, middle row in the low byte
  lef_ram #(.WIDTH(LW), .DEPTH(MAX_WIDTH)) u_lines (
    .clk     (clk),
    .wr_en   (a_leave),
    .wr_addr (a_addr),
    .wr_data (wr_data),
    .rd_en   (req_pop),
    .rd_addr (req_addr),
    .rd_data (ram_q)
  );

  // Forward a write that lands on the address being read in the same cycle
  always_ff @(posedge clk) begin
    if (req_pop) begin
      byp      <= a_leave && (a_addr == req_addr);
      byp_data <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (req_pop) begin
      a_valid <= 1'b1;
    end else if (a_leave) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_pop) begin
      a_addr  <= req_addr;
      a_value <= req_value;
      a_flags <= req_flags;
    end
  end

  // Build the 3x3 neighborhood and the Laplacian response
  always_comb begin
    line      = byp ? byp_data : ram_q;
    col_px[0] = line[LW-1:lef_pkg::PIX_W];
    col_px[1] = line[lef_pkg::PIX_W-1:0];
    col_px[2] = a_value;
    wr_data   = {col_px[1], a_value};

    row_ok = {a_flags.bot_ok, 1'b1, a_flags.top_ok};
    col_ok = {a_flags.right_ok, 1'b1, a_flags.left_ok};

    nsum = '0;
    for (int i = 0; i < 3; i++) begin
      tap[i][0] = win1[i];
      tap[i][1] = win2[i];
      tap[i][2] = col_px[i];
      for (int j = 0; j < 3; j++) begin
        if (!(i == 1 && j == 1) && row_ok[i] && col_ok[j]) begin
          nsum = nsum + 11'(tap[i][j]);
        end
      end
    end

    center8 = {tap[1][1], 3'b000};
    diff    = {1'b0, center8} - {1'b0, nsum};

    // Clamp to the grey range
    if (diff[11]) begin
      res_edge = '0;
    end else if (diff[10:0] > 11'd255) begin
      res_edge = 8'd255;
    end else begin
      res_edge = diff[7:0];
    end

    res_push = a_leave && a_flags.emit;
    res_last = a_flags.last;
  end

  // Slide the window by one column, drop it at frame end, restart or reset
  always_ff @(posedge clk) begin
    if (rst || restart || (a_leave && a_flags.emit && a_flags.last)) begin
      for (int i = 0; i < 3; i++) begin
        win1[i] <= '0;
        win2[i] <= '0;
      end
    end else if (a_leave) begin
      for (int i = 0; i < 3; i++) begin
        win1[i] <= win2[i];
        win2[i] <= col_px[i];
      end
    end
  end

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    a_valid && !a_leave |=> a_valid && $stable(a_addr) && $stable(a_value))
    else $error("stalled request in stage A changed");
  a_window_cleared: assert property (@(posedge clk) disable iff (rst)
    a_leave && a_flags.emit && a_flags.last |=> (win2[1] == '0) && (win1[1] == '0))
    else $error("window not cleared after frame end");

endmodule

>>> hw/rtl/laplacian_edge_filter_3x3_unit.sv
// 3x3 eight-neighbor Laplacian edge filter. Push the red channel of a frame one pixel
// per request in raster order, then image_width+1 flush requests (kind = 1) to drain it;
// each result is 8*center minus the eight neighbors (outside pixels count as zero),
// clamped to 0..255, and results pop in raster order one row plus one pixel behind the
// input, frame_end marking the last pixel. The block takes one pixel per clock and
// gives one result per clock while the consumer keeps popping; an accepted request
// passes the request queue, then the line-buffer read and window stage, before it
// reaches the result queue, from which its result can be popped, and the one
// registered-read line-buffer RAM of MAX_WIDTH 16-bit entries is read and written once
// per pixel. Writing image_width or image_height restarts the frame; write them only
// while no frame is in flight. No clearing pass follows reset.
module laplacian_edge_filter_3x3_unit #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                              clk,
  input  logic                              rst,
  // pixel input
  input  logic                              push,
  output logic                              full,
  input  logic                              kind,
  input  logic [lef_pkg::PIX_W-1:0]         red_value,
  // result output
  output logic                              empty,
  input  logic                              pop,
  output logic [lef_pkg::PIX_W-1:0]         edge_value,
  output logic                              frame_end,
  // configuration
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lef_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [lef_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int FW = $bits(lef_pkg::lef_flags_t);
  localparam int DW = AW + lef_pkg::PIX_W + FW;
  localparam int RW = lef_pkg::PIX_W + 1;

  logic                accept;
  logic                restart;
  logic [AW-1:0]       f_addr;
  lef_pkg::pixel_t     f_value;
  lef_pkg::lef_flags_t f_flags;

  logic                dq_empty;
  logic                dq_pop;
  logic [DW-1:0]       dq_rdata;
  logic [AW-1:0]       b_addr;
  lef_pkg::pixel_t     b_value;
  lef_pkg::lef_flags_t b_flags;

  logic                res_push;
  logic                res_full;
  lef_pkg::pixel_t     res_edge;
  logic                res_last;

  assign cfg_ready = 1'b1;
  assign accept    = push && !full;

  lef_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .kind      (kind),
    .red_value (red_value),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .restart   (restart),
    .addr      (f_addr),
    .value     (f_value),
    .flags     (f_flags)
  );

  // Short queue between classification and execution
  lef_fifo #(.WIDTH(DW), .DEPTH(2)) u_req_q (
    .clk   (clk),
    .rst   (rst),
    .push  (accept),
    .wdata ({f_addr, f_value, f_flags}),
    .full  (full),
    .pop   (dq_pop),
    .rdata (dq_rdata),
    .empty (dq_empty)
  );

  assign {b_addr, b_value, b_flags} = dq_rdata;

  lef_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
    .clk       (clk),
    .rst       (rst),
    .restart   (restart),
    .req_valid (!dq_empty),
    .req_pop   (dq_pop),
    .req_addr  (b_addr),
    .req_value (b_value),
    .req_flags (b_flags),
    .res_push  (res_push),
    .res_full  (res_full),
    .res_edge  (res_edge),
    .res_last  (res_last)
  );

  // Result queue toward the consumer
  lef_fifo #(.WIDTH(RW), .DEPTH(2)) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata ({res_edge, res_last}),
    .full  (res_full),
    .pop   (pop && !empty),
    .rdata ({edge_value, frame_end}),
    .empty (empty)
  );

endmodule

>>> bench/lef_edge_checker.sv
module lef_edge_checker #(
  parameter int LINE_DEPTH = 1024
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  input  logic                            full,
  input  logic                            kind,
  input  logic [lef_pkg::PIX_W-1:0]       red_value,
  input  logic                            empty,
  input  logic                            pop,
  input  logic [lef_pkg::PIX_W-1:0]       edge_value,
  input  logic                            frame_end,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [lef_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [lef_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                              failures,
  output int                              pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    lef_pkg::pixel_t level;
    logic            last;
  } edge_pixel_t;

  // Expected edge pixels, oldest first
  edge_pixel_t pending_edges[$];

  // Shadow copy of the filter state
  lef_pkg::pixel_t                 upper_mem  [LINE_DEPTH];
  lef_pkg::pixel_t                 middle_mem [LINE_DEPTH];
  lef_pkg::pixel_t                 win        [3][3];
  int                              col_pos;
  int                              row_pos;
  logic [lef_pkg::WIDTH_REG_W-1:0] frame_width;
  logic [lef_pkg::HEIGHT_W-1:0]    frame_height;
  int                              fail_total = 0;

  task automatic report_mismatch(input string msg);
    $display("%0d ns: %s", $time, msg);
    fail_total++;
  endtask

  // Return the window and the raster position to the frame start
  function automatic void restart_frame();
    win     = '{default: '0};
    col_pos = 0;
    row_pos = 0;
  endfunction

  // Advance the shadow filter by one pixel request and queue any edge pixel it yields
  task automatic laplace_step(input logic is_flush, input lef_pkg::pixel_t red);
    int              w, h, c, r, cr, cc, pr, pc, sum;
    lef_pkg::pixel_t v;
    lef_pkg::pixel_t col [3];
    lef_pkg::pixel_t tap [3][3];
    edge_pixel_t     res;
    w = (frame_width == 0) ? 1 :
        ((frame_width > LINE_DEPTH) ? LINE_DEPTH : int'(frame_width));
    h = (frame_height == 0) ? 1 :
        ((frame_height > lef_pkg::HEIGHT_LIMIT) ? lef_pkg::HEIGHT_LIMIT : int'(frame_height));
    v = is_flush ? '0 : red;
    c = col_pos;
    r = row_pos;
    col[0] = '0;
    col[1] = '0;
    col[2] = v;

    // Read the two rows above, then roll the line buffers down
    if (c < LINE_DEPTH) begin
      col[0]        = upper_mem[c];
      col[1]        = middle_mem[c];
      upper_mem[c]  = middle_mem[c];
      middle_mem[c] = v;
    end

    for (int i = 0; i < 3; i++) begin
      tap[i][0] = win[i][1];
      tap[i][1] = win[i][2];
      tap[i][2] = (c >= 1) ? col[i] : '0;
    end

    // Center sits one row up and one column left; at column zero it wraps to the row end
    if (c >= 1) begin
      cr = r - 1;
      cc = c - 1;
    end else begin
      cr = r - 2;
      cc = w - 1;
    end

    for (int i = 0; i < 3; i++) begin
      win[i][0] = win[i][1];
      win[i][1] = win[i][2];
      win[i][2] = col[i];
    end

    if (c + 1 >= w) begin
      col_pos = 0;
      row_pos = (row_pos + 1) & 8191;
    end else begin
      col_pos = c + 1;
    end

    // Sum the taps that lie inside the frame, then clamp
    if (cr >= 0 && cr < h) begin
      sum = 0;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          pr = cr - 1 + i;
          pc = cc - 1 + j;
          if (pr >= 0 && pr < h && pc >= 0 && pc < w) begin
            sum += (i == 1 && j == 1) ? 8 * int'(tap[i][j]) : -int'(tap[i][j]);
          end
        end
      end
      if (sum > 255) sum = 255;
      if (sum < 0) sum = 0;
      res.level = lef_pkg::pixel_t'(sum);
      res.last  = (cr == h - 1) && (cc == w - 1);
      pending_edges.push_back(res);
      if (res.last) restart_frame();
    end
  endtask

  always @(posedge clk) begin : watch
    edge_pixel_t want;
    if (rst) begin
      for (int i = 0; i < LINE_DEPTH; i++) begin
        upper_mem[i]  = '0;
        middle_mem[i] = '0;
      end
      frame_width  = lef_pkg::WIDTH_REG_W'(640);
      frame_height = lef_pkg::HEIGHT_W'(480);
      restart_frame();
      pending_edges.delete();
    end else begin
      // Compare a popped result against the oldest expectation
      if (pop && !empty) begin
        if (pending_edges.size() == 0) begin
          report_mismatch($sformatf("result with nothing expected: edge_value=%0d frame_end=%0b",
                                    edge_value, frame_end));
        end else begin
          want = pending_edges.pop_front();
          if (edge_value !== want.level) begin
            report_mismatch($sformatf("edge_value got %0d want %0d", edge_value, want.level));
          end
          if (frame_end !== want.last) begin
            report_mismatch($sformatf("frame_end got %0b want %0b", frame_end, want.last));
          end
        end
      end

      // Track register writes; either geometry register restarts the frame
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          lef_pkg::REG_IMAGE_WIDTH: begin
            frame_width = cfg_data[lef_pkg::WIDTH_REG_W-1:0];
            restart_frame();
          end
          lef_pkg::REG_IMAGE_HEIGHT: begin
            frame_height = cfg_data[lef_pkg::HEIGHT_W-1:0];
            restart_frame();
          end
          default: begin
          end
        endcase
      end

      if (push && !full) laplace_step(kind == lef_pkg::KIND_FLUSH, red_value);
    end
    failures <= fail_total;
    pending  <= pending_edges.size();
  end

endmodule

>>> bench/laplacian_edge_filter_3x3_unit_tb.sv
module laplacian_edge_filter_3x3_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int   MAX_WIDTH   = 1024;
  localparam int   ITEM_TARGET = 550;
  localparam int   GAP_END     = 470;
  localparam logic KIND_PIXEL  = ~lef_pkg::KIND_FLUSH;
  localparam logic [lef_pkg::CFG_INDEX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [lef_pkg::CFG_INDEX_W-1:0] REG_SPARE_HI = 2'd3;

  logic                            clk = 1'b0;
  logic                            rst;
  logic                            push;
  logic                            full;
  logic                            kind;
  lef_pkg::pixel_t                 red_value;
  logic                            empty;
  logic                            pop;
  lef_pkg::pixel_t                 edge_value;
  logic                            frame_end;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [lef_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [lef_pkg::CFG_DATA_W-1:0]  cfg_data;
  int                              fail_count;
  int                              pending_results;

  // Stimulus shaping state
  logic gaps_on;
  bit   paused_once;
  int   eff_w;
  int   eff_h;
  int   item_total;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  laplacian_edge_filter_3x3_unit #(
    .MAX_WIDTH(MAX_WIDTH)
  ) DUT (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .kind       (kind),
    .red_value  (red_value),
    .empty      (empty),
    .pop        (pop),
    .edge_value (edge_value),
    .frame_end  (frame_end),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  lef_edge_checker #(
    .LINE_DEPTH(MAX_WIDTH)
  ) u_checker (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .kind       (kind),
    .red_value  (red_value),
    .empty      (empty),
    .pop        (pop),
    .edge_value (edge_value),
    .frame_end  (frame_end),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .failures   (fail_count),
    .pending    (pending_results)
  );

  // Favor the clamp extremes, otherwise any level
  function automatic lef_pkg::pixel_t pick_red();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      default: return lef_pkg::pixel_t'($urandom_range(0, 255));
    endcase
  endfunction

  // Send one request, with an optional idle burst in front
  task automatic push_item(input logic k, input lef_pkg::pixel_t v);
    int gap;
    if (item_total >= GAP_END) gaps_on = 1'b0;
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 5);
      @(negedge clk);
      push <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    push      <= 1'b1;
    kind      <= k;
    red_value <= v;
    do @(posedge clk); while (full);
    item_total++;
  endtask

  // Hold the input until every expected result has popped
  task automatic hold_until_drained();
    @(negedge clk);
    push <= 1'b0;
    while (pending_results != 0) @(posedge clk);
  endtask

  // Drain, then give the three-stage path time to empty out
  task automatic settle();
    hold_until_drained();
    repeat (8) @(posedge clk);
  endtask

  task automatic write_register(input logic [lef_pkg::CFG_INDEX_W-1:0] idx, input int value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[lef_pkg::CFG_DATA_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic apply_geometry(input int w_raw, input int h_raw);
    settle();
    write_register(lef_pkg::REG_IMAGE_WIDTH, w_raw);
    write_register(lef_pkg::REG_IMAGE_HEIGHT, h_raw);
    eff_w = (w_raw == 0) ? 1 : ((w_raw > MAX_WIDTH) ? MAX_WIDTH : w_raw);
    eff_h = (h_raw == 0) ? 1 :
            ((h_raw > lef_pkg::HEIGHT_LIMIT) ? lef_pkg::HEIGHT_LIMIT : h_raw);
  endtask

  // Stream up to pix_limit frame pixels; a complete frame is followed by its drain
  task automatic stream_frame(input int pix_limit);
    int n;
    int drain;
    for (n = 0; n < eff_w * eff_h && n < pix_limit; n++) begin
      if (!paused_once && n == 3) begin
        hold_until_drained();
        paused_once = 1'b1;
      end
      push_item(($urandom_range(0, 15) == 0) ? lef_pkg::KIND_FLUSH : KIND_PIXEL, pick_red());
    end
    if (n == eff_w * eff_h) begin
      drain = eff_w + 1;
      // Now and then shift the drain by up to one request, short or long
      if ($urandom_range(0, 9) == 0) drain = drain + $urandom_range(0, 2) - 1;
      repeat (drain) begin
        push_item(($urandom_range(0, 7) == 0) ? KIND_PIXEL : lef_pkg::KIND_FLUSH, pick_red());
      end
    end
  endtask

  // Result side: pop with random stall bursts
  initial begin : result_drain
    int stall_left;
    pop        = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (gaps_on && stall_left == 0 && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 5);
      end
      if (stall_left > 0) begin
        pop <= 1'b0;
        stall_left--;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int w_sel;
    int w_raw;
    int h_raw;
    int k;
    rst         = 1'b1;
    push        = 1'b0;
    kind        = KIND_PIXEL;
    red_value   = '0;
    cfg_valid   = 1'b0;
    cfg_index   = lef_pkg::REG_IMAGE_WIDTH;
    cfg_data    = '0;
    gaps_on     = 1'b1;
    paused_once = 1'b0;
    item_total  = 0;
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    // 3x3 frame: saturating high and low responses, a flush inside the frame,
    // and a pixel in a drain slot
    apply_geometry(3, 3);
    push_item(KIND_PIXEL, 8'd255);
    push_item(KIND_PIXEL, 8'd0);
    push_item(KIND_PIXEL, 8'd255);
    push_item(KIND_PIXEL, 8'd0);
    push_item(KIND_PIXEL, 8'd255);
    push_item(KIND_PIXEL, 8'd0);
    push_item(KIND_PIXEL, 8'd255);
    push_item(lef_pkg::KIND_FLUSH, 8'd255);
    push_item(KIND_PIXEL, 8'd255);
    push_item(lef_pkg::KIND_FLUSH, 8'd0);
    push_item(KIND_PIXEL, 8'd170);
    push_item(lef_pkg::KIND_FLUSH, 8'd0);
    push_item(lef_pkg::KIND_FLUSH, 8'd0);

    // Zero geometry acts as a single pixel; unused indexes must change nothing
    apply_geometry(0, 0);
    write_register(REG_SPARE_LO, $urandom_range(0, 8191));
    write_register(REG_SPARE_HI, $urandom_range(0, 8191));
    push_item(KIND_PIXEL, 8'd85);
    push_item(lef_pkg::KIND_FLUSH, 8'd0);
    push_item(lef_pkg::KIND_FLUSH, 8'd0);

    // Single column
    apply_geometry(1, 2);
    push_item(KIND_PIXEL, 8'd255);
    push_item(KIND_PIXEL, 8'd0);
    push_item(lef_pkg::KIND_FLUSH, 8'd0);
    push_item(lef_pkg::KIND_FLUSH, 8'd0);

    // Oversized width clamps to the line buffer depth; partial frame only
    apply_geometry(2047, 1);
    stream_frame(40);
    // Oversized and exact-limit heights, partial frames only
    apply_geometry(2, 8191);
    stream_frame(40);
    apply_geometry(MAX_WIDTH, lef_pkg::HEIGHT_LIMIT);
    stream_frame(30);

    // Random phases: mostly well-formed frames, some raw noise, until the budget is spent
    while (item_total < ITEM_TARGET) begin
      w_sel = $urandom_range(0, 9);
      if (w_sel == 0) w_raw = 0;
      else if (w_sel <= 6) w_raw = $urandom_range(1, 8);
      else w_raw = $urandom_range(9, 40);
      if ($urandom_range(0, 9) == 0) h_raw = 0;
      else if ($urandom_range(0, 4) == 0) h_raw = $urandom_range(7, 12);
      else h_raw = $urandom_range(1, 6);
      apply_geometry(w_raw, h_raw);
      gaps_on = (item_total < GAP_END) && ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(5, 30)) begin
          push_item(logic'($urandom_range(0, 1)), lef_pkg::pixel_t'($urandom_range(0, 255)));
        end
      end else begin
        repeat ($urandom_range(1, 3)) stream_frame(ITEM_TARGET - item_total);
        if ($urandom_range(0, 3) == 0 && item_total < ITEM_TARGET) begin
          stream_frame($urandom_range(1, ITEM_TARGET - item_total));
        end
      end
    end

    // Wait out the tail, bounded
    @(negedge clk);
    push <= 1'b0;
    for (k = 0; k < 20000 && pending_results != 0; k++) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending_results == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin : watchdog
    #4_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
